### src/assert_macros.svh
// Assertion helper macros for the deque RTL.
// No dependencies; pulled in by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check with no reset gating.
`define ASSERT_CLKED(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

// Clocked check, disabled while the synchronous reset is high.
`define ASSERT_SYNC(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`endif

### src/bdeq_pkg.sv
// Shared constants and types for the bounded deque.
// No dependencies; used by bdeq_ptr and the top level.
`timescale 1ns / 1ps

package bdeq_pkg;

  localparam int DEPTH_DEFAULT = 1024;
  localparam int DATA_W        = 32;
  localparam int ACT_W         = 3;
  localparam int CAP_W         = 11;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  // action codes; anything else behaves as a query
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_REAR  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_REAR   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_QUERY      = 3'd4;

  // per-word status from the pointer unit
  typedef struct packed {
    logic ok;     // action taken
    logic wr_en;  // push writes the store
    logic empty;  // no entries after the action
    logic full;   // count at capacity after the action
  } bdeq_flags_t;

endpackage

### src/bounded_double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit words, top level.
// Depends on bdeq_pkg, bdeq_ptr, bdeq_ram and assert_macros.svh.
`timescale 1ns / 1ps
//
//  channel  | direction | ports               | contents
//  ---------+-----------+---------------------+---------------------------------------
//  s_axis   | in        | tvalid/tready/tdata | tuser: action; tdata: value
//  m_axis   | out       | tvalid/tready/tdata | ok, front, rear, empty, full
//  cfg      | in        | cfg_we/cfg_wdata    | capacity (11 bits)
//
// For each word, the accept edge updates the pointers, writes a push into
// the store and launches both store reads; the edge that ends ST_READ loads
// the result register. The two reads (front and rear) come from two mirrored
// RAM copies, one read port each. A result waiting on m_axis stalls the
// input side only if it is not taken in the cycle a new word arrives.
// Reset (rst, synchronous): empty deque, head at zero, capacity 1024. The
// store has no clear; only entries written by a push ever reach m_axis.

module bounded_double_ended_queue #(
  parameter int DEPTH = bdeq_pkg::DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_we,
  input  logic [bdeq_pkg::CAP_W-1:0]     cfg_wdata,
  // input words
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [31:0]                    s_axis_tdata,   // [31:0] value
  input  logic [2:0]                     s_axis_tuser,   // [2:0] action
  // result words
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [71:0]                    m_axis_tdata    // [0] ok, [32:1] front_value,
                                                         // [64:33] rear_value,
                                                         // [65] is_empty, [66] is_full,
                                                         // [71:67] zero
);

  `include "assert_macros.svh"

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW = bdeq_pkg::DATA_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t state, state_next;

  logic                  s_accept;
  bdeq_pkg::bdeq_flags_t flags;
  logic [AW-1:0]         wr_addr, rd_front_addr, rd_rear_addr;
  logic [DW-1:0]         front_rdata, rear_rdata;

  // per-word status held across the read cycle
  logic                  pend_ok, pend_empty, pend_full;
  logic                  fwd_front, fwd_rear;
  logic [DW-1:0]         fwd_value;

  logic [DW-1:0]         front_sel, rear_sel;

  // result register
  logic                  out_ok, out_empty, out_full;
  logic [DW-1:0]         out_front, out_rear;

  // take a word only when the result register is free by the read cycle
  assign s_axis_tready = (state == ST_IDLE) && (!m_axis_tvalid || m_axis_tready);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  bdeq_ptr #(
    .DEPTH(DEPTH)
  ) u_ptr (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .step          (s_accept),
    .action        (s_axis_tuser),
    .flags         (flags),
    .wr_addr       (wr_addr),
    .rd_front_addr (rd_front_addr),
    .rd_rear_addr  (rd_rear_addr)
  );

  // mirrored store copies: same writes, one read port each
  bdeq_ram #(
    .WIDTH(DW),
    .DEPTH(DEPTH)
  ) u_ram_front (
    .clk   (clk),
    .we    (s_accept && flags.wr_en),
    .waddr (wr_addr),
    .wdata (s_axis_tdata),
    .re    (s_accept),
    .raddr (rd_front_addr),
    .rdata (front_rdata)
  );

  bdeq_ram #(
    .WIDTH(DW),
    .DEPTH(DEPTH)
  ) u_ram_rear (
    .clk   (clk),
    .we    (s_accept && flags.wr_en),
    .waddr (wr_addr),
    .wdata (s_axis_tdata),
    .re    (s_accept),
    .raddr (rd_rear_addr),
    .rdata (rear_rdata)
  );

  // The push write and the reads share an edge; the RAM returns the old
  // entry there, so a read of the slot just written takes the pushed word.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      pend_ok    <= flags.ok;
      pend_empty <= flags.empty;
      pend_full  <= flags.full;
      fwd_front  <= flags.wr_en && (rd_front_addr == wr_addr);
      fwd_rear   <= flags.wr_en && (rd_rear_addr == wr_addr);
      fwd_value  <= s_axis_tdata;
    end
  end

  always_comb begin
    front_sel = fwd_front ? fwd_value : front_rdata;
    rear_sel  = fwd_rear  ? fwd_value : rear_rdata;
    if (pend_empty) begin
      front_sel = '1;  // -1 when empty
      rear_sel  = '1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_accept) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_READ) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      out_ok    <= pend_ok;
      out_front <= front_sel;
      out_rear  <= rear_sel;
      out_empty <= pend_empty;
      out_full  <= pend_full;
    end
  end

  assign m_axis_tdata = {5'b0, out_full, out_empty, out_rear, out_front, out_ok};

  // ---- checks ----
  `ASSERT_SYNC(a_accept_then_read, clk, rst, s_accept |=> (state == ST_READ), "accept did not start a read cycle")
  `ASSERT_SYNC(a_read_then_valid, clk, rst, (state == ST_READ) |=> m_axis_tvalid, "read cycle produced no result")
  `ASSERT_SYNC(a_out_free_in_read, clk, rst, (state == ST_READ) |-> !m_axis_tvalid, "result register busy when loaded")

endmodule

### src/bdeq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bdeq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/bdeq_ptr.sv
// Deque pointer unit: head index, entry count and capacity register.
// Computes store write and read addresses per word. Depends on bdeq_pkg.
`timescale 1ns / 1ps

module bdeq_ptr #(
  parameter int DEPTH = bdeq_pkg::DEPTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [bdeq_pkg::CAP_W-1:0]           cfg_wdata,
  input  logic                                 step,
  input  logic [bdeq_pkg::ACT_W-1:0]           action,
  output bdeq_pkg::bdeq_flags_t                flags,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_front_addr,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_rear_addr
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = (CW > bdeq_pkg::CAP_W) ? CW : bdeq_pkg::CAP_W;
  localparam logic [AW-1:0] LAST     = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_X  = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [AW-1:0]              head, head_next;
  logic [CW-1:0]              count, count_next;
  logic [bdeq_pkg::CAP_W-1:0] capacity;
  logic                       full_now;

  // sum below twice the depth: one compare and subtract
  function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
    logic [AW:0] d;
    d = (s >= DEPTH_X) ? (s - DEPTH_X) : s;
    return d[AW-1:0];
  endfunction

  function automatic logic at_cap(input logic [CW-1:0] n,
                                  input logic [bdeq_pkg::CAP_W-1:0] cap);
    return (WW'(n) >= WW'(cap)) || (n == FULL_CNT);
  endfunction

  assign full_now = at_cap(count, capacity);

  always_comb begin
    head_next   = head;
    count_next  = count;
    flags.ok    = 1'b1;
    flags.wr_en = 1'b0;
    wr_addr     = head;
    case (action)
      bdeq_pkg::ACT_PUSH_FRONT: begin
        if (full_now) begin
          flags.ok = 1'b0;
        end else begin
          head_next   = (head == '0) ? LAST : head - AW'(1);
          count_next  = count + CW'(1);
          flags.wr_en = 1'b1;
          wr_addr     = head_next;
        end
      end
      bdeq_pkg::ACT_PUSH_REAR: begin
        if (full_now) begin
          flags.ok = 1'b0;
        end else begin
          count_next  = count + CW'(1);
          flags.wr_en = 1'b1;
          wr_addr     = wrap((AW + 1)'(head) + (AW + 1)'(count));
        end
      end
      bdeq_pkg::ACT_POP_FRONT: begin
        if (count == '0) begin
          flags.ok = 1'b0;
        end else begin
          head_next  = (head == LAST) ? '0 : head + AW'(1);
          count_next = count - CW'(1);
        end
      end
      bdeq_pkg::ACT_POP_REAR: begin
        if (count == '0) begin
          flags.ok = 1'b0;
        end else begin
          count_next = count - CW'(1);
        end
      end
      default: begin
        // query and unused codes change nothing
      end
    endcase
    flags.empty   = (count_next == '0);
    flags.full    = at_cap(count_next, capacity);
    rd_front_addr = head_next;
    // meaningless when the deque ends up empty; masked downstream
    rd_rear_addr  = wrap((AW + 1)'(head_next) + (AW + 1)'(count_next) - (AW + 1)'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      capacity <= bdeq_pkg::CAP_RESET;
    end else begin
      if (step) begin
        head  <= head_next;
        count <= count_next;
      end
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
    end
  end

endmodule
